@@ hdl/sphash_pkg.sv @@
// ----------------------------------------------------------------------------
// sphash_pkg
// Types and constants shared by the sampled polynomial byte hash unit.
// ----------------------------------------------------------------------------
package sphash_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned LEN_W        = 31;
    localparam int unsigned HASH_W       = 32;
    localparam int unsigned SHAMT_W      = 5;
    localparam int unsigned QUEUE_DEPTH  = 4;

    localparam logic [LEN_W-1:0] SHORT_LIMIT  = 31'd64;
    localparam logic [LEN_W-1:0] WINDOW_BYTES = 31'd16;
    localparam logic [LEN_W-1:0] HALF_BACKOFF = 31'd8;
    localparam logic [LEN_W-1:0] POS_MAX      = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  data_length;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic              length_error;
    } out_item_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic               selected;
        logic               last;
        logic               error;
        logic [SHAMT_W-1:0] shamt;
    } cmd_t;

endpackage

@@ hdl/sphash_front.sv @@
// ----------------------------------------------------------------------------
// sphash_front
// Accepts input transfers, tracks the byte position and classifies each byte.
// ----------------------------------------------------------------------------
module sphash_front
    import sphash_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic [LEN_W-1:0] pos_reg;
    logic [LEN_W-1:0] pos_next;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] mid;
    logic [LEN_W-1:0] expect_pos;
    logic             sel;

    assign len     = s_data.data_length;
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        mid        = (len >> 1) - HALF_BACKOFF;
        expect_pos = (len == '0) ? '0 : len - 1'b1;
        if (pos_reg >= len) begin
            sel = 1'b0;
        end else if (len < SHORT_LIMIT) begin
            sel = 1'b1;
        end else if (pos_reg < WINDOW_BYTES) begin
            sel = 1'b1;
        end else if (pos_reg >= mid && pos_reg < mid + WINDOW_BYTES) begin
            sel = 1'b1;
        end else if (pos_reg >= len - WINDOW_BYTES) begin
            sel = 1'b1;
        end else begin
            sel = 1'b0;
        end
    end

    always_comb begin
        q_cmd.data_byte = s_data.data_byte;
        q_cmd.selected  = sel;
        q_cmd.last      = s_data.last_byte;
        q_cmd.error     = (pos_reg != expect_pos);
        q_cmd.shamt     = len[SHAMT_W-1:0];
    end

    always_comb begin
        pos_next = pos_reg;
        if (q_push) begin
            if (s_data.last_byte) begin
                pos_next = '0;
            end else if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

@@ hdl/sphash_queue.sv @@
// ----------------------------------------------------------------------------
// sphash_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module sphash_queue
    import sphash_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/sphash_back.sv @@
// ----------------------------------------------------------------------------
// sphash_back
// Runs the base-257 accumulator and drives the registered result channel.
// ----------------------------------------------------------------------------
module sphash_back
    import sphash_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_empty,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [HASH_W-1:0] acc_reg;
    logic [HASH_W-1:0] acc_next;
    logic [HASH_W-1:0] acc_upd;
    logic              m_valid_reg;
    logic              m_valid_next;
    out_item_t         m_data_reg;
    out_item_t         m_data_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = !q_empty && (!q_cmd.last || out_free);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        // acc * 257 as shift-add
        acc_upd = q_cmd.selected
                ? (acc_reg << 8) + acc_reg + HASH_W'(q_cmd.data_byte)
                : acc_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (q_pop) begin
            acc_next = acc_upd;
            if (q_cmd.last) begin
                acc_next                 = '0;
                m_valid_next             = 1'b1;
                m_data_next.hash_value   = acc_upd + (acc_upd << q_cmd.shamt);
                m_data_next.length_error = q_cmd.error;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ hdl/sampled_polynomial_byte_hash_unit.sv @@
// ----------------------------------------------------------------------------
// sampled_polynomial_byte_hash_unit
// Sampled base-257 polynomial hash over a byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
//  channel  direction  payload      handshake
//  s_       in         in_item_t    s_valid / s_ready
//  m_       out        out_item_t   m_valid / m_ready
//
//  One byte transfer per cycle sustained while the queue is not full; the front classifies
//  and queues it, the back pops it and folds selected bytes into the accumulator.
//  A hash is registered onto m_ when the back pops its last byte from the queue and m_ is free.
//  aresetn (synchronous) clears position, queue, accumulator and m_valid.
//  A stalled m_ lets the queue fill; s_ready drops only when it is full.
// ----------------------------------------------------------------------------
module sampled_polynomial_byte_hash_unit
    import sphash_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic q_full;
    logic q_push;
    logic q_empty;
    logic q_pop;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    sphash_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    sphash_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    sphash_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
